// ----- hw/rtl/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the 3x3 binary majority filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int ADDR_W   = $clog2(MAX_COLS);
	localparam int POS_W    = 10;
	localparam int CFG_W    = 11;
	localparam int IDX_W    = 1;
	localparam int WIN_W    = 9;
	localparam int CNT_W    = 4;

	localparam logic [IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [IDX_W-1:0] REG_COLS = 1'b1;

	localparam logic [CFG_W-1:0] MIN_SIZE  = CFG_W'(3);
	localparam logic [CFG_W-1:0] ROWS_HI   = CFG_W'(MAX_ROWS);
	localparam logic [CFG_W-1:0] COLS_HI   = CFG_W'(MAX_COLS);
	localparam logic [WIN_W-1:0] NBR_MASK  = 9'h1EF;
	localparam logic [CNT_W-1:0] MAJ_LIMIT = 4'd4;

	typedef struct packed {
		logic mask_bit;
		logic frame_start;
	} pix_t;

	typedef struct packed {
		logic             has_pixel;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             out_bit;
	} res_t;

	// bit 0: row r-2 (upper), bit 1: row r-1 (middle)
	typedef logic [1:0] line_pair_t;

endpackage

// ----- hw/rtl/binary_majority_filter_3x3.sv -----
// A pixel transfer passes the line store read and stage-1 registers, then the
//   window and result registers; a result-side stall can hold it in between.
// Throughput: one pixel per cycle unless stalled, set by the single read port.
// Each result carries the filtered pixel cols_in_use+1 positions back.
// Reset clears position, window, valids and sets both sizes to 1024;
//   line store contents stay undefined until written.
// ----------------------------------------------------------------------------
// binary_majority_filter_3x3
// Streaming 3x3 majority filter on a binary mask in raster order.
// ----------------------------------------------------------------------------
module binary_majority_filter_3x3
	import bmf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  pix_t             pix,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res
);

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		r = v;
		if (v < MIN_SIZE) begin
			r = MIN_SIZE;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] popcount(input logic [WIN_W-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WIN_W; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

	logic [CFG_W-1:0] rows_q, cols_q;
	logic [POS_W-1:0] row_q, col_q;

	logic             valid_s1;
	logic             bit_s1;
	logic [POS_W-1:0] row_s1, col_s1;
	logic             fwd_s1;
	line_pair_t       fwd_data_s1;

	logic [WIN_W-1:0] window_q;
	logic             res_valid_q;
	res_t             res_q;

	logic             pix_acc, adv, commit;
	logic [CFG_W-1:0] r_a, c_a, rn_a, cn_a;
	logic [ADDR_W-1:0] addr_a;
	line_pair_t       rd_data, col_eff, wr_data;
	logic [2:0]       column;
	logic [WIN_W-1:0] win_nxt;
	logic             has, inner, maj;
	logic [CFG_W-1:0] crow, ccol;
	res_t             res_nxt;

	assign adv       = !res_valid_q || !res_stall;
	assign commit    = valid_s1 && adv;
	assign pix_stall = valid_s1 && !adv;
	assign pix_acc   = pix_valid && !pix_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_HI;
			cols_q <= COLS_HI;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= clamp_size(cfg_data, ROWS_HI);
				REG_COLS: cols_q <= clamp_size(cfg_data, COLS_HI);
			endcase
		end
	end

	// raster position of the incoming pixel and of the next one
	always_comb begin
		r_a = {1'b0, row_q};
		c_a = {1'b0, col_q};
		if (pix.frame_start) begin
			r_a = '0;
			c_a = '0;
		end else begin
			if (c_a >= cols_q) begin
				c_a = '0;
				r_a = r_a + 1'b1;
			end
			if (r_a >= rows_q) begin
				r_a = '0;
			end
		end
		cn_a = c_a + 1'b1;
		rn_a = r_a;
		if (cn_a >= cols_q) begin
			cn_a = '0;
			rn_a = r_a + 1'b1;
			if (rn_a >= rows_q) begin
				rn_a = '0;
			end
		end
	end

	assign addr_a = c_a[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (pix_acc) begin
				row_q    <= rn_a[POS_W-1:0];
				col_q    <= cn_a[POS_W-1:0];
				valid_s1 <= 1'b1;
				fwd_s1   <= commit && (addr_a == col_s1[ADDR_W-1:0]);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			bit_s1      <= pix.mask_bit;
			row_s1      <= r_a[POS_W-1:0];
			col_s1      <= c_a[POS_W-1:0];
			fwd_data_s1 <= wr_data;
		end
	end

	bmf_line_store u_line_store (
		.clk     (clk),
		.rd_en   (pix_acc),
		.rd_addr (addr_a),
		.rd_data (rd_data),
		.wr_en   (commit),
		.wr_addr (col_s1[ADDR_W-1:0]),
		.wr_data (wr_data)
	);

	// window and majority decision
	always_comb begin
		col_eff = fwd_s1 ? fwd_data_s1 : rd_data;
		wr_data = {bit_s1, col_eff[1]};
		column  = {bit_s1, col_eff[1], col_eff[0]};
		win_nxt = {window_q[WIN_W-4:0], column};
		has     = (row_s1 >= POS_W'(2)) || (row_s1 == POS_W'(1) && col_s1 != '0);
		if (col_s1 != '0) begin
			crow = {1'b0, row_s1} - 1'b1;
			ccol = {1'b0, col_s1} - 1'b1;
		end else begin
			crow = {1'b0, row_s1} - CFG_W'(2);
			ccol = cols_q - 1'b1;
		end
		inner = (crow != '0) && (crow + CFG_W'(2) <= rows_q)
			&& (ccol != '0) && (ccol + CFG_W'(2) <= cols_q);
		maj   = popcount(win_nxt & NBR_MASK) > MAJ_LIMIT;
		res_nxt.has_pixel = has;
		res_nxt.out_row   = has ? crow[POS_W-1:0] : '0;
		res_nxt.out_col   = has ? ccol[POS_W-1:0] : '0;
		res_nxt.out_bit   = has && inner && maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				window_q <= win_nxt;
			end
			if (adv) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- hw/rtl/bmf_line_store.sv -----
// ----------------------------------------------------------------------------
// bmf_line_store
// Two line stores packed side by side: one write and one registered read.
// ----------------------------------------------------------------------------
module bmf_line_store
	import bmf_pkg::*;
(
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output line_pair_t        rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  line_pair_t        wr_data
);

	line_pair_t mem [MAX_COLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/bmf_checker.sv -----
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the majority filter, bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker
	import bmf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("pixel stalled without result back-pressure");

	a_transfer_out: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall ##1 (!res_valid || !res_stall) |=> res_valid)
		else $error("accepted pixel produced no result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.has_pixel |->
			res.out_row == '0 && res.out_col == '0 && !res.out_bit)
		else $error("filling result not all zero");

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.has_pixel && (res.out_row == '0 || res.out_col == '0)
			|-> !res.out_bit)
		else $error("border pixel set");

endmodule

bind binary_majority_filter_3x3 bmf_checker u_bmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ----- test/tb_binary_majority_filter_3x3.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_majority_filter_3x3
// Streams binary mask frames of many sizes through the 3x3 majority filter.
// A software copy of the filter predicts each result. Every result transfer
// is compared field by field with the oldest prediction. Both handshakes idle
// at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_binary_majority_filter_3x3;
	import bmf_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 800000;
	localparam int LONG_HOLD   = 400;
	localparam int SMALL_ITEMS = 2000;
	localparam int HOLD_ITEMS  = 100;
	localparam int DRAIN_WAIT  = 8;

	class filtered_pixel_board;
		bit               prev2_row [MAX_COLS];
		bit               prev1_row [MAX_COLS];
		bit               prev2_set [MAX_COLS];
		bit               prev1_set [MAX_COLS];
		logic [WIN_W-1:0] window;
		int unsigned      row_pos;
		int unsigned      col_pos;
		logic [CFG_W-1:0] rows_reg;
		logic [CFG_W-1:0] cols_reg;
		res_t             filtered_due [$];
		int               errors;

		function new();
			window   = '0;
			row_pos  = 0;
			col_pos  = 0;
			rows_reg = ROWS_HI;
			cols_reg = COLS_HI;
			errors   = 0;
		endfunction

		function int unsigned clamp(logic [CFG_W-1:0] v, logic [CFG_W-1:0] hi);
			if (v < MIN_SIZE)
				return MIN_SIZE;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == REG_ROWS)
				rows_reg = v;
			else
				cols_reg = v;
		endfunction

		function bit covers(int unsigned width);
			for (int i = 0; i < width; i++)
				if (!prev2_set[i] || !prev1_set[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_pixel(pix_t p);
			int unsigned rows, cols, r, c, crow, ccol;
			res_t want;
			rows = clamp(rows_reg, ROWS_HI);
			cols = clamp(cols_reg, COLS_HI);
			if (p.frame_start) begin
				r = 0;
				c = 0;
			end else begin
				r = row_pos;
				c = col_pos;
				if (c >= cols) begin
					c = 0;
					r++;
				end
				if (r >= rows)
					r = 0;
			end
			window = {window[5:0], p.mask_bit, prev1_row[c], prev2_row[c]};
			want = '0;
			if (r >= 2 || (r == 1 && c >= 1)) begin
				want.has_pixel = 1'b1;
				if (c >= 1) begin
					crow = r - 1;
					ccol = c - 1;
				end else begin
					crow = r - 2;
					ccol = cols - 1;
				end
				want.out_row = POS_W'(crow);
				want.out_col = POS_W'(ccol);
				if (crow >= 1 && crow + 2 <= rows && ccol >= 1 && ccol + 2 <= cols)
					want.out_bit = ($countones(window & NBR_MASK) > MAJ_LIMIT);
			end
			prev2_row[c] = prev1_row[c];
			prev2_set[c] = prev1_set[c];
			prev1_row[c] = p.mask_bit;
			prev1_set[c] = 1'b1;
			c++;
			if (c >= cols) begin
				c = 0;
				r++;
				if (r >= rows)
					r = 0;
			end
			row_pos = r;
			col_pos = c;
			filtered_due.push_back(want);
		endfunction

		function void check_filtered(res_t got);
			res_t want;
			if (filtered_due.size() == 0) begin
				$error("result transfer with no pixel outstanding");
				errors++;
				return;
			end
			want = filtered_due.pop_front();
			if (got.has_pixel !== want.has_pixel) begin
				$error("has_pixel: expected %0d, actual %0d", want.has_pixel, got.has_pixel);
				errors++;
			end
			if (got.out_row !== want.out_row) begin
				$error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
				errors++;
			end
			if (got.out_col !== want.out_col) begin
				$error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
				errors++;
			end
			if (got.out_bit !== want.out_bit) begin
				$error("out_bit: expected %0d, actual %0d", want.out_bit, got.out_bit);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_ROWS;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             pix_valid = 1'b0;
	logic             pix_stall;
	pix_t             pix       = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	res_t             res;

	filtered_pixel_board board = new();
	bit                  quiet   = 1'b0;
	bit                  hold_go = 1'b0;
	int unsigned         cycle_count = 0;

	binary_majority_filter_3x3 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				board.set_reg(cfg_index, cfg_data);
			if (pix_valid && !pix_stall)
				board.note_pixel(pix);
			if (res_valid && !res_stall)
				board.check_filtered(res);
		end
	end

	initial begin : result_sink
		int unsigned burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				burst   = LONG_HOLD;
			end else if (burst == 0 && !quiet && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 14);
			end
			if (burst > 0) begin
				res_stall <= 1'b1;
				burst--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic push_pixel(logic mask_v, logic start_v);
		pix_t p;
		p.mask_bit    = mask_v;
		p.frame_start = start_v;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (pix_stall);
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		do @(posedge clk); while (board.filtered_due.size() != 0);
	endtask

	task automatic set_frame_size(logic [CFG_W-1:0] rows_v, logic [CFG_W-1:0] cols_v);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROWS;
		cfg_data  <= rows_v;
		@(posedge clk);
		cfg_index <= REG_COLS;
		cfg_data  <= cols_v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		logic [WIN_W-1:0] pattern [3];
		int unsigned      sent, count, rows_raw, cols_raw, rows_eff, cols_eff;
		int unsigned      dens, phase;
		bit               fresh, mask_v, start_v;
		// all set; five neighbours with centre clear; four neighbours with centre set
		pattern[0] = 9'h1FF;
		pattern[1] = 9'h02F;
		pattern[2] = 9'h155;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// undersized registers clamp to 3x3; second frame arrives by overrun
		set_frame_size(CFG_W'(0), CFG_W'(2));
		for (int f = 0; f < 3; f++)
			for (int k = 0; k < 9; k++)
				push_pixel(pattern[f][k], k == 0 && f != 1);
		drain();

		// random frame, then the long hold, then one full-width frame without idling
		sent  = 0;
		phase = 0;
		while (sent < SMALL_ITEMS) begin
			fresh = 1'b1;
			dens  = $urandom_range(0, 10);
			if (phase == 2) begin
				rows_raw = $urandom_range(1025, 2047);
				cols_raw = $urandom_range(1024, 2047);
				count    = 2 * MAX_COLS + 16;
			end else begin
				case ($urandom_range(0, 9))
					0:       rows_raw = $urandom_range(0, 2);
					1:       rows_raw = $urandom_range(1024, 2047);
					default: rows_raw = $urandom_range(3, 12);
				endcase
				if ($urandom_range(0, 9) == 0)
					cols_raw = $urandom_range(0, 2);
				else
					cols_raw = $urandom_range(3, 24);
				rows_eff = board.clamp(CFG_W'(rows_raw), ROWS_HI);
				cols_eff = board.clamp(CFG_W'(cols_raw), COLS_HI);
				count = $urandom_range(1, 3) * rows_eff * cols_eff + $urandom_range(0, cols_eff);
				if (count > 400)
					count = $urandom_range(cols_eff + 2, 400);
				// continue the old raster position only over columns already stored
				if (phase > 0 && board.covers(cols_eff) && $urandom_range(0, 3) == 0)
					fresh = 1'b0;
			end
			set_frame_size(CFG_W'(rows_raw), CFG_W'(cols_raw));
			quiet = (phase == 2) || ($urandom_range(0, 3) == 0);
			if (phase == 1) begin
				quiet   = 1'b1;
				hold_go = 1'b1;
				count   = HOLD_ITEMS;
			end
			for (int k = 0; k < count; k++) begin
				mask_v  = ($urandom_range(0, 9) < dens);
				start_v = (k == 0 && fresh) || ($urandom_range(0, 127) == 0);
				push_pixel(mask_v, start_v);
			end
			drain();
			sent += count;
			phase++;
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.errors == 0 && board.filtered_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_line_store.sv
hw/rtl/binary_majority_filter_3x3.sv
hw/rtl/bmf_checker.sv
test/tb_binary_majority_filter_3x3.sv
